>>> rtl/srd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg
// Shared widths, constants and beat structures for the scaled radial
// deadzone pipeline.
// ----------------------------------------------------------------------------
package srd_pkg;

  localparam int AXIS_W = 16;
  localparam int DZ_W   = AXIS_W - 1;
  localparam int MAG_W  = AXIS_W;
  localparam int SQ_W   = 2 * AXIS_W;
  localparam int ROOT_W = AXIS_W;
  localparam int REM_W  = ROOT_W + 1;
  localparam int DEN_W  = 2 * AXIS_W - 1;
  localparam int Q_W    = AXIS_W + 1;
  localparam int PRE_SH = Q_W - (AXIS_W - 1);
  localparam int LAT    = 3 + ROOT_W + 3 + Q_W + 1;

  localparam logic [MAG_W-1:0] AXIS_ONE = MAG_W'(1) << (AXIS_W - 1);
  localparam logic [DZ_W-1:0]  DZ_RESET = DZ_W'(AXIS_ONE >> 2);

  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic             nx;
    logic             ny;
    logic [DZ_W-1:0]  dz;
    logic             in_dz;
    logic             zero;
  } srd_side_t;

  typedef struct packed {
    logic nx;
    logic ny;
    logic in_dz;
    logic zero;
  } srd_tail_t;

  typedef struct packed {
    logic [SQ_W-1:0]   src;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } srd_sqrt_t;

  typedef struct packed {
    logic [DEN_W-1:0] r;
    logic [Q_W-1:0]   q;
    logic [Q_W-1:0]   nb;
    logic             sat;
  } srd_lane_t;

endpackage

>>> rtl/scaled_radial_deadzone_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scaled_radial_deadzone_top
// Scaled radial deadzone for one analog stick sample per clock.
// ----------------------------------------------------------------------------
// A sample is taken on every clock with start high; busy is never raised.
// Each result appears on the out_ ports for one cycle with out_strobe high,
// after it has passed 3 squaring/compare stages, a chain of 16 square-root
// cells, 3 scaling stages, a chain of 17 divider cells and the output
// register. There is no backpressure: the receiver must take
// every beat as it comes. Write cfg_wdata only while no sample is in flight.
// ----------------------------------------------------------------------------
module scaled_radial_deadzone_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [srd_pkg::AXIS_W-1:0] in_axis_x_in,
  input  logic signed [srd_pkg::AXIS_W-1:0] in_axis_y_in,
  output logic                             out_strobe,
  output logic signed [srd_pkg::AXIS_W-1:0] out_axis_x_out,
  output logic signed [srd_pkg::AXIS_W-1:0] out_axis_y_out,
  output logic                             out_in_deadzone,
  input  logic                             cfg_we,
  input  logic [srd_pkg::DZ_W-1:0]          cfg_wdata
);
  import srd_pkg::*;

  logic             accept;
  logic [LAT-1:0]   vld_r;
  logic [DZ_W-1:0]  dz_r;

  logic [MAG_W-1:0] xu;
  logic [MAG_W-1:0] yu;
  srd_side_t        sd_a_nxt;
  srd_side_t        sd_a_r;

  srd_side_t        sd_b_r;
  logic [SQ_W-1:0]  sqx_b_r;
  logic [SQ_W-1:0]  sqy_b_r;
  logic [SQ_W-1:0]  dz2_b_r;
  logic [SQ_W-1:0]  msq;

  srd_sqrt_t        sq_st [ROOT_W+1];
  srd_side_t        sq_sd [ROOT_W+1];

  srd_side_t        sd_d_r;
  logic [MAG_W-1:0] mag_d_r;
  logic [MAG_W-1:0] diff_d_r;
  logic [MAG_W-1:0] span_d_r;

  srd_tail_t        tl_e_r;
  logic [DEN_W-1:0] px_e_r;
  logic [DEN_W-1:0] py_e_r;
  logic [DEN_W-1:0] den_e_r;

  logic [DEN_W-1:0] dv_den [Q_W+1];
  srd_lane_t        dv_lx [Q_W+1];
  srd_lane_t        dv_ly [Q_W+1];
  srd_tail_t        dv_tl [Q_W+1];

  logic [MAG_W-1:0] xo_r;
  logic [MAG_W-1:0] yo_r;
  logic             dzo_r;

  function automatic srd_lane_t lane_init(input logic [DEN_W-1:0] p,
                                          input logic [DEN_W-1:0] d);
    logic [DEN_W-1:0] hi;
    srd_lane_t        o;
    hi    = p >> PRE_SH;
    o.sat = (hi >= d);
    o.r   = o.sat ? '0 : hi;
    o.q   = '0;
    o.nb  = Q_W'(p[PRE_SH-1:0]) << (Q_W - PRE_SH);
    return o;
  endfunction

  function automatic logic [MAG_W-1:0] finish(input srd_lane_t l, input logic neg);
    logic             big;
    logic [MAG_W-1:0] m;
    if (neg) begin
      big = l.sat || (l.q > Q_W'(AXIS_ONE));
      m   = big ? AXIS_ONE : l.q[MAG_W-1:0];
      m   = ~m + 1'b1;
    end else begin
      big = l.sat || (l.q >= Q_W'(AXIS_ONE));
      m   = big ? (AXIS_ONE - 1'b1) : l.q[MAG_W-1:0];
    end
    return m;
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // valid pipe and deadzone register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      dz_r  <= DZ_RESET;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
      if (cfg_we) begin
        dz_r <= cfg_wdata;
      end
    end
  end

  // magnitudes and signs
  always_comb begin
    xu             = in_axis_x_in;
    yu             = in_axis_y_in;
    sd_a_nxt.nx    = xu[MAG_W-1];
    sd_a_nxt.ny    = yu[MAG_W-1];
    sd_a_nxt.ax    = xu[MAG_W-1] ? (~xu + 1'b1) : xu;
    sd_a_nxt.ay    = yu[MAG_W-1] ? (~yu + 1'b1) : yu;
    sd_a_nxt.dz    = dz_r;
    sd_a_nxt.in_dz = 1'b0;
    sd_a_nxt.zero  = 1'b0;
  end

  always_ff @(posedge clk) begin
    sd_a_r  <= sd_a_nxt;
    sd_b_r  <= sd_a_r;
    sqx_b_r <= SQ_W'(sd_a_r.ax) * SQ_W'(sd_a_r.ax);
    sqy_b_r <= SQ_W'(sd_a_r.ay) * SQ_W'(sd_a_r.ay);
    dz2_b_r <= SQ_W'(sd_a_r.dz) * SQ_W'(sd_a_r.dz);
  end

  assign msq = sqx_b_r + sqy_b_r;

  always_ff @(posedge clk) begin
    sq_st[0].src  <= msq;
    sq_st[0].rem  <= '0;
    sq_st[0].root <= '0;
    sq_sd[0]       <= '{ax: sd_b_r.ax, ay: sd_b_r.ay, nx: sd_b_r.nx, ny: sd_b_r.ny,
                         dz: sd_b_r.dz, in_dz: (msq < dz2_b_r), zero: (msq == '0)};
  end

  // square root chain
  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    srd_sqrt_cell u_cell (
      .clk    (clk),
      .st_in  (sq_st[i]),
      .sd_in  (sq_sd[i]),
      .st_out (sq_st[i+1]),
      .sd_out (sq_sd[i+1])
    );
  end

  // scaling terms
  always_ff @(posedge clk) begin
    sd_d_r   <= sq_sd[ROOT_W];
    mag_d_r  <= sq_st[ROOT_W].root;
    diff_d_r <= sq_st[ROOT_W].root - MAG_W'(sq_sd[ROOT_W].dz);
    span_d_r <= AXIS_ONE - MAG_W'(sq_sd[ROOT_W].dz);
  end

  always_ff @(posedge clk) begin
    tl_e_r  <= '{nx: sd_d_r.nx, ny: sd_d_r.ny, in_dz: sd_d_r.in_dz, zero: sd_d_r.zero};
    px_e_r  <= DEN_W'(sd_d_r.ax) * DEN_W'(diff_d_r);
    py_e_r  <= DEN_W'(sd_d_r.ay) * DEN_W'(diff_d_r);
    den_e_r <= DEN_W'(mag_d_r) * DEN_W'(span_d_r);
  end

  always_ff @(posedge clk) begin
    dv_den[0] <= den_e_r;
    dv_lx[0]  <= lane_init(px_e_r, den_e_r);
    dv_ly[0]  <= lane_init(py_e_r, den_e_r);
    dv_tl[0]  <= tl_e_r;
  end

  // divider chain
  for (genvar j = 0; j < Q_W; j++) begin : g_div
    srd_div_cell u_cell (
      .clk     (clk),
      .den_in  (dv_den[j]),
      .lx_in   (dv_lx[j]),
      .ly_in   (dv_ly[j]),
      .tl_in   (dv_tl[j]),
      .den_out (dv_den[j+1]),
      .lx_out  (dv_lx[j+1]),
      .ly_out  (dv_ly[j+1]),
      .tl_out  (dv_tl[j+1])
    );
  end

  // saturate, restore sign, output beat
  always_ff @(posedge clk) begin
    dzo_r <= dv_tl[Q_W].in_dz;
    if (dv_tl[Q_W].in_dz || dv_tl[Q_W].zero) begin
      xo_r <= '0;
      yo_r <= '0;
    end else begin
      xo_r <= finish(dv_lx[Q_W], dv_tl[Q_W].nx);
      yo_r <= finish(dv_ly[Q_W], dv_tl[Q_W].ny);
    end
  end

  assign out_strobe      = vld_r[LAT-1];
  assign out_axis_x_out  = $signed(xo_r);
  assign out_axis_y_out  = $signed(yo_r);
  assign out_in_deadzone = dzo_r;

  a_strobe_follows_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LAT))
    else $error("result beat without a matching sample");

  a_deadzone_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_in_deadzone) |-> (out_axis_x_out == '0 && out_axis_y_out == '0))
    else $error("deadzone beat with non-zero axes");

  a_x_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_axis_x_out[AXIS_W-1]) |-> $past(in_axis_x_in[AXIS_W-1], LAT))
    else $error("x output negative for a non-negative input");

  a_y_sign_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_axis_y_out[AXIS_W-1]) |-> $past(in_axis_y_in[AXIS_W-1], LAT))
    else $error("y output negative for a non-negative input");

endmodule

>>> rtl/srd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_sqrt_cell
// One digit of the integer square root: takes two radicand bits, settles
// one root bit and passes the beat on to the next cell.
// ----------------------------------------------------------------------------
module srd_sqrt_cell (
  input  logic              clk,
  input  srd_pkg::srd_sqrt_t st_in,
  input  srd_pkg::srd_side_t sd_in,
  output srd_pkg::srd_sqrt_t st_out,
  output srd_pkg::srd_side_t sd_out
);
  import srd_pkg::*;

  logic [REM_W+1:0] cat;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  srd_sqrt_t        st_nxt;
  srd_sqrt_t        st_r;
  srd_side_t        sd_r;

  always_comb begin
    cat   = {st_in.rem, st_in.src[SQ_W-1 -: 2]};
    trial = {1'b0, st_in.root, 2'b01};
    diff  = cat - trial;
    st_nxt.src = st_in.src << 2;
    if (cat >= trial) begin
      st_nxt.rem  = diff[REM_W-1:0];
      st_nxt.root = {st_in.root[ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = cat[REM_W-1:0];
      st_nxt.root = {st_in.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    sd_r <= sd_in;
  end

  assign st_out = st_r;
  assign sd_out = sd_r;

endmodule

>>> rtl/srd_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_div_cell
// One restoring division step for both axes against a shared divisor:
// brings down one dividend bit, settles one quotient bit per axis.
// ----------------------------------------------------------------------------
module srd_div_cell (
  input  logic                     clk,
  input  logic [srd_pkg::DEN_W-1:0] den_in,
  input  srd_pkg::srd_lane_t       lx_in,
  input  srd_pkg::srd_lane_t       ly_in,
  input  srd_pkg::srd_tail_t       tl_in,
  output logic [srd_pkg::DEN_W-1:0] den_out,
  output srd_pkg::srd_lane_t       lx_out,
  output srd_pkg::srd_lane_t       ly_out,
  output srd_pkg::srd_tail_t       tl_out
);
  import srd_pkg::*;

  logic [DEN_W-1:0] den_r;
  srd_lane_t        lx_r;
  srd_lane_t        ly_r;
  srd_tail_t        tl_r;
  srd_lane_t        lx_nxt;
  srd_lane_t        ly_nxt;

  function automatic srd_lane_t step(input srd_lane_t l, input logic [DEN_W-1:0] d);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] dd;
    logic [DEN_W:0] sub;
    srd_lane_t      o;
    sh    = {l.r, l.nb[Q_W-1]};
    dd    = {1'b0, d};
    sub   = sh - dd;
    o.nb  = l.nb << 1;
    o.sat = l.sat;
    if (sh >= dd) begin
      o.r = sub[DEN_W-1:0];
      o.q = {l.q[Q_W-2:0], 1'b1};
    end else begin
      o.r = sh[DEN_W-1:0];
      o.q = {l.q[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    lx_nxt = step(lx_in, den_in);
    ly_nxt = step(ly_in, den_in);
  end

  always_ff @(posedge clk) begin
    den_r <= den_in;
    lx_r  <= lx_nxt;
    ly_r  <= ly_nxt;
    tl_r  <= tl_in;
  end

  assign den_out = den_r;
  assign lx_out  = lx_r;
  assign ly_out  = ly_r;
  assign tl_out  = tl_r;

endmodule
